FILE: rtl/core/pic_p2g_pkg.sv
// Shared constants, payload types and control types of the particle-to-grid step unit.
`timescale 1ns / 1ps
`default_nettype none
package pic_p2g_pkg;

  localparam int GRID_W        = 64;
  localparam int GRID_H        = 64;
  localparam int POS_FRAC_BITS = 8;

  localparam int CELLS     = GRID_W * GRID_H;
  localparam int CELL_AW   = $clog2(CELLS);
  localparam int ONE_CELL  = 1 << POS_FRAC_BITS;
  localparam int HALF_CELL = 1 << (POS_FRAC_BITS - 1);
  localparam int CELL_IB   = 16 - POS_FRAC_BITS + 1;  // corner index width, one spare bit
  localparam int WW        = 2 * POS_FRAC_BITS + 1;   // corner weight width
  localparam int LO_BOUND  = 3 * HALF_CELL;
  localparam int HI_X_RAW  = (2 * GRID_W - 3) * HALF_CELL;
  localparam int HI_Y_RAW  = (2 * GRID_H - 3) * HALF_CELL;
  localparam int HI_X      = (HI_X_RAW > 65535) ? 65535 : HI_X_RAW;
  localparam int HI_Y      = (HI_Y_RAW > 65535) ? 65535 : HI_Y_RAW;

  localparam int WSUM_W = 32;
  localparam int VSUM_W = 48;
  localparam int WORD_W = WSUM_W + VSUM_W;

  localparam logic [1:0] OP_CLEAR    = 2'd0;
  localparam logic [1:0] OP_PARTICLE = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  localparam logic       CFG_TIME_STEP = 1'b0;
  localparam logic       CFG_GRAVITY   = 1'b1;
  localparam logic [15:0] TIME_STEP_RST = 16'd1092;
  localparam logic [15:0] GRAVITY_RST   = 16'd256;

  localparam logic [1:0] LAST_CORNER = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [5:0]         cell_x;
    logic [5:0]         cell_y;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        new_pos_x;
    logic [15:0]        new_pos_y;
    logic signed [15:0] new_vel_x;
    logic signed [15:0] new_vel_y;
    logic signed [15:0] grid_u;
    logic signed [15:0] grid_v;
    logic               u_empty;
    logic               v_empty;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_CLR, DP_KIN1, DP_KIN2, DP_KIN3, DP_KIN4,
    DP_RD, DP_MUL, DP_WR, DP_QRD, DP_DIVGO
  } dp_op_t;

  typedef enum logic [1:0] {
    OUT_NONE, OUT_ZERO, OUT_PART, OUT_QRY
  } out_sel_t;

  typedef struct packed {
    logic     cap;
    dp_op_t   op;
    out_sel_t out;
    logic [1:0] corner;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_CLR_RST, ST_IDLE, ST_CLR_OP, ST_K1, ST_K2, ST_K3, ST_K4,
    ST_RD, ST_MUL, ST_WR, ST_QRD, ST_QLAT, ST_DIV
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/core/pic_particle_to_grid_step_unit.sv
// Top level of the particle-in-cell particle-to-grid step unit.
//
// Command-style block: an item transfers on a rising edge with start high and busy
// low; each result sits on out_data for exactly one cycle with out_valid high and
// cannot be held off, so the receiver must take it then. After reset the grid sums
// are swept to zero, one cell per cycle of both grid memories, with busy high
// (configuration writes are still taken). Per item, with the result strobe in the
// cycle after the last busy one: clear runs the same sweep; particle step = 4
// kinematics steps plus, for each of the 4 corners, read, multiply and saturating
// write on the single-port u and v memories in parallel; query = memory read,
// latch, 48 bit-serial divide steps and the divider's done flag; unused opcode 3
// (result next cycle).
`timescale 1ns / 1ps
`default_nettype none
module pic_particle_to_grid_step_unit
  import pic_p2g_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: owns the state and the corner count
  pic_p2g_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .opcode(in_data.opcode),
    .status(status), .busy(busy), .cmd(cmd)
  );

  // arithmetic, grid memories, dividers and the result register
  pic_p2g_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .status(status), .out_valid(out_valid), .out_data(out_data)
  );

endmodule
`default_nettype wire

FILE: rtl/core/pic_p2g_div.sv
// Bit-serial signed-by-unsigned divider with truncation and 16-bit saturation.
`timescale 1ns / 1ps
`default_nettype none
module pic_p2g_div
  import pic_p2g_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     go,
  input  wire logic signed [VSUM_W-1:0] dividend,
  input  wire logic [WSUM_W-1:0]        divisor,
  output logic                          done,
  output logic signed [15:0]            quo
);

  localparam int CW = $clog2(VSUM_W + 1);

  logic [VSUM_W-1:0] mag_r, mag_nxt;
  logic [WSUM_W-1:0] rem_r, rem_nxt, dvs_r;
  logic              neg_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              run_r, run_nxt, done_r, done_nxt;
  logic [WSUM_W:0]   rem_sh;
  logic              fit;

  always_comb begin
    rem_sh  = {rem_r, mag_r[VSUM_W-1]};
    fit     = rem_sh >= {1'b0, dvs_r};
    rem_nxt = fit ? WSUM_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[WSUM_W-1:0];
    mag_nxt = {mag_r[VSUM_W-2:0], fit};
    cnt_nxt = cnt_r - CW'(1);
    run_nxt = run_r && (cnt_r != CW'(1));
    done_nxt = run_r && (cnt_r == CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(VSUM_W);
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      if (run_r) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      neg_r <= dividend[VSUM_W-1];
      mag_r <= dividend[VSUM_W-1] ? VSUM_W'(-dividend) : VSUM_W'(dividend);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_comb begin
    if (!neg_r) quo = (mag_r > VSUM_W'(32767)) ? 16'sd32767 : 16'(mag_r);
    else        quo = (mag_r > VSUM_W'(32768)) ? -16'sd32768 : 16'(-mag_r);
  end

  assign done = done_r;

endmodule
`default_nettype wire

FILE: rtl/core/pic_p2g_ctrl.sv
// Sequencer for clear sweeps, particle steps and cell queries.
`timescale 1ns / 1ps
`default_nettype none
module pic_p2g_ctrl
  import pic_p2g_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] opcode,
  input  wire dp_status_t status,
  output logic            busy,
  output ctrl_cmd_t       cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] corner_r, corner_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR_RST;
      corner_r <= '0;
    end else begin
      state_r  <= state_nxt;
      corner_r <= corner_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    corner_nxt = corner_r;
    case (state_r)
      ST_CLR_RST, ST_CLR_OP: if (status.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        corner_nxt = '0;
        if (start) begin
          case (opcode)
            OP_CLEAR:    state_nxt = ST_CLR_OP;
            OP_PARTICLE: state_nxt = ST_K1;
            OP_QUERY:    state_nxt = ST_QRD;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_K1:  state_nxt = ST_K2;
      ST_K2:  state_nxt = ST_K3;
      ST_K3:  state_nxt = ST_K4;
      ST_K4:  state_nxt = ST_RD;
      ST_RD:  state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_WR;
      ST_WR: begin
        corner_nxt = corner_r + 2'd1;
        state_nxt  = (corner_r == LAST_CORNER) ? ST_IDLE : ST_RD;
      end
      ST_QRD:  state_nxt = ST_QLAT;
      ST_QLAT: state_nxt = ST_DIV;
      ST_DIV:  if (status.div_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.op     = DP_NOP;
    cmd.out    = OUT_NONE;
    cmd.corner = corner_r;
    busy       = (state_r != ST_IDLE);
    case (state_r)
      ST_CLR_RST: cmd.op = DP_CLR;
      ST_CLR_OP: begin
        cmd.op = DP_CLR;
        if (status.clr_last) cmd.out = OUT_ZERO;
      end
      ST_IDLE: begin
        cmd.cap = start;
        if (start && opcode != OP_CLEAR && opcode != OP_PARTICLE && opcode != OP_QUERY)
          cmd.out = OUT_ZERO;
      end
      ST_K1:  cmd.op = DP_KIN1;
      ST_K2:  cmd.op = DP_KIN2;
      ST_K3:  cmd.op = DP_KIN3;
      ST_K4:  cmd.op = DP_KIN4;
      ST_RD:  cmd.op = DP_RD;
      ST_MUL: cmd.op = DP_MUL;
      ST_WR: begin
        cmd.op = DP_WR;
        if (corner_r == LAST_CORNER) cmd.out = OUT_PART;
      end
      ST_QRD:  cmd.op = DP_QRD;
      ST_QLAT: cmd.op = DP_DIVGO;
      ST_DIV:  if (status.div_done) cmd.out = OUT_QRY;
      default: cmd.op = DP_NOP;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/pic_p2g_dp.sv
// Datapath: kinematics, corner read-modify-write on the u and v grid memories, query.
`timescale 1ns / 1ps
`default_nettype none
module pic_p2g_dp
  import pic_p2g_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctrl_cmd_t   cmd,
  input  wire in_item_t    in_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  output dp_status_t       status,
  output logic             out_valid,
  output out_item_t        out_data
);

  // configuration
  logic [15:0] time_step_r, gravity_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TIME_STEP_RST;
      gravity_r   <= GRAVITY_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TIME_STEP) time_step_r <= cfg_data;
      if (cfg_index == CFG_GRAVITY)   gravity_r   <= cfg_data;
    end
  end

  // captured item
  in_item_t item_r;
  logic     oor_r;
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      item_r <= in_data;
      oor_r  <= (32'(in_data.cell_x) >= GRID_W) || (32'(in_data.cell_y) >= GRID_H);
    end
  end

  // kinematics
  logic [16:0]        gd_r;
  logic signed [32:0] vxdt_r, vydt_r;
  logic signed [15:0] vy_r;
  logic signed [17:0] px_r;
  logic [15:0]        pxc_r, pyc_r;
  logic signed [15:0] vxc_r, vyc_r;

  logic [32:0]        gd_full;
  logic signed [33:0] rx, ry;
  logic signed [17:0] vy_d, py_n;
  logic signed [15:0] vy_sat;

  always_comb begin
    gd_full = {1'b0, 32'(gravity_r) * 32'(time_step_r)} + 33'd32768;
    rx      = 34'(vxdt_r) + 34'sd32768;
    ry      = 34'(vydt_r) + 34'sd32768;
    vy_d    = 18'(item_r.vel_y) - $signed({1'b0, gd_r});
    if (vy_d > 18'sd32767)       vy_sat = 16'sd32767;
    else if (vy_d < -18'sd32768) vy_sat = -16'sd32768;
    else                         vy_sat = 16'(vy_d);
    py_n    = $signed({2'b00, item_r.pos_y}) + ry[33:16];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_KIN1: begin
        gd_r   <= gd_full[32:16];
        vxdt_r <= item_r.vel_x * $signed({1'b0, time_step_r});
      end
      DP_KIN2: begin
        vy_r <= vy_sat;
        px_r <= $signed({2'b00, item_r.pos_x}) + rx[33:16];
      end
      DP_KIN3: vydt_r <= vy_r * $signed({1'b0, time_step_r});
      DP_KIN4: begin
        if (px_r < 18'(LO_BOUND)) begin
          pxc_r <= 16'(LO_BOUND);
          vxc_r <= '0;
        end else if (px_r > 18'(HI_X)) begin
          pxc_r <= 16'(HI_X);
          vxc_r <= '0;
        end else begin
          pxc_r <= 16'(px_r);
          vxc_r <= item_r.vel_x;
        end
        if (py_n < 18'(LO_BOUND)) begin
          pyc_r <= 16'(LO_BOUND);
          vyc_r <= '0;
        end else if (py_n > 18'(HI_Y)) begin
          pyc_r <= 16'(HI_Y);
          vyc_r <= '0;
        end else begin
          pyc_r <= 16'(py_n);
          vyc_r <= vy_r;
        end
      end
      default: ;
    endcase
  end

  // corner geometry
  function automatic logic [WW-1:0] corner_w(input logic [15:0] qx, input logic [15:0] qy,
                                             input logic [1:0] c);
    logic [POS_FRAC_BITS:0] fx, fy, wx, wy;
    fx = {1'b0, qx[POS_FRAC_BITS-1:0]};
    fy = {1'b0, qy[POS_FRAC_BITS-1:0]};
    wx = c[0] ? fx : (POS_FRAC_BITS+1)'(ONE_CELL) - fx;
    wy = c[1] ? fy : (POS_FRAC_BITS+1)'(ONE_CELL) - fy;
    return WW'(wx * wy);
  endfunction

  function automatic logic [CELL_AW:0] corner_a(input logic [15:0] qx, input logic [15:0] qy,
                                                input logic [1:0] c);
    logic [CELL_IB-1:0] gx, gy;
    logic               ok;
    gx = {1'b0, qx[15:POS_FRAC_BITS]} + CELL_IB'(c[0]);
    gy = {1'b0, qy[15:POS_FRAC_BITS]} + CELL_IB'(c[1]);
    ok = (32'(gx) < GRID_W) && (32'(gy) < GRID_H);
    return {ok, CELL_AW'(32'(gy) * GRID_W + 32'(gx))};
  endfunction

  logic [15:0]      qvx, quy;
  logic [CELL_AW:0] ca_u, ca_v;
  logic [CELL_AW-1:0] qidx;
  always_comb begin
    quy  = pyc_r - 16'(HALF_CELL);
    qvx  = pxc_r - 16'(HALF_CELL);
    ca_u = corner_a(pxc_r, quy, cmd.corner);
    ca_v = corner_a(qvx, pyc_r, cmd.corner);
    qidx = CELL_AW'(32'(item_r.cell_y) * GRID_W + 32'(item_r.cell_x));
  end

  // corner registers
  logic [WW-1:0]          w_u_r, w_v_r;
  logic [CELL_AW-1:0]     a_u_r, a_v_r;
  logic                   ok_u_r, ok_v_r;
  logic signed [WW+16:0]  val_u_r, val_v_r;

  always_ff @(posedge clk) begin
    if (cmd.op == DP_RD) begin
      w_u_r  <= corner_w(pxc_r, quy, cmd.corner);
      w_v_r  <= corner_w(qvx, pyc_r, cmd.corner);
      a_u_r  <= ca_u[CELL_AW-1:0];
      a_v_r  <= ca_v[CELL_AW-1:0];
      ok_u_r <= ca_u[CELL_AW];
      ok_v_r <= ca_v[CELL_AW];
    end
    if (cmd.op == DP_MUL) begin
      val_u_r <= $signed({1'b0, w_u_r}) * vxc_r;
      val_v_r <= $signed({1'b0, w_v_r}) * vyc_r;
    end
  end

  // grid memories, word = {weight sum, value sum}
  logic [WORD_W-1:0]  mem_u [CELLS];
  logic [WORD_W-1:0]  mem_v [CELLS];
  logic [WORD_W-1:0]  rd_u_r, rd_v_r;
  logic [CELL_AW-1:0] clr_addr_r;
  logic               re;
  logic [CELL_AW-1:0] ra_u, ra_v, wa_u, wa_v;
  logic               we_u, we_v;
  logic [WORD_W-1:0]  wd_u, wd_v;

  function automatic logic [WORD_W-1:0] acc(input logic [WORD_W-1:0] word,
                                            input logic [WW-1:0] w,
                                            input logic signed [WW+16:0] val);
    logic [WSUM_W:0]          ws;
    logic signed [VSUM_W:0]   vs;
    logic [WSUM_W-1:0]        wn;
    logic [VSUM_W-1:0]        vn;
    ws = {1'b0, word[WORD_W-1:VSUM_W]} + (WSUM_W+1)'(w);
    wn = ws[WSUM_W] ? '1 : ws[WSUM_W-1:0];
    vs = $signed({word[VSUM_W-1], word[VSUM_W-1:0]}) + (VSUM_W+1)'(val);
    if (vs[VSUM_W] != vs[VSUM_W-1]) vn = vs[VSUM_W] ? {1'b1, {(VSUM_W-1){1'b0}}}
                                                   : {1'b0, {(VSUM_W-1){1'b1}}};
    else vn = vs[VSUM_W-1:0];
    return {wn, vn};
  endfunction

  always_comb begin
    re   = (cmd.op == DP_RD) || (cmd.op == DP_QRD);
    ra_u = (cmd.op == DP_QRD) ? qidx : ca_u[CELL_AW-1:0];
    ra_v = (cmd.op == DP_QRD) ? qidx : ca_v[CELL_AW-1:0];
    if (cmd.op == DP_CLR) begin
      we_u = 1'b1;
      we_v = 1'b1;
      wa_u = clr_addr_r;
      wa_v = clr_addr_r;
      wd_u = '0;
      wd_v = '0;
    end else begin
      we_u = (cmd.op == DP_WR) && ok_u_r;
      we_v = (cmd.op == DP_WR) && ok_v_r;
      wa_u = a_u_r;
      wa_v = a_v_r;
      wd_u = acc(rd_u_r, w_u_r, val_u_r);
      wd_v = acc(rd_v_r, w_v_r, val_v_r);
    end
  end

  always_ff @(posedge clk) begin
    if (we_u) mem_u[wa_u] <= wd_u;
    if (re) rd_u_r <= mem_u[ra_u];
  end

  always_ff @(posedge clk) begin
    if (we_v) mem_v[wa_v] <= wd_v;
    if (re) rd_v_r <= mem_v[ra_v];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.op == DP_CLR)
      clr_addr_r <= status.clr_last ? '0 : clr_addr_r + CELL_AW'(1);
  end

  // query dividers
  logic               go, done_u, done_v;
  logic signed [15:0] quo_u, quo_v;
  logic               emp_u, emp_v;

  assign go = (cmd.op == DP_DIVGO);

  pic_p2g_div u_div_u (
    .clk(clk), .rst_n(rst_n), .go(go),
    .dividend($signed(rd_u_r[VSUM_W-1:0])), .divisor(rd_u_r[WORD_W-1:VSUM_W]),
    .done(done_u), .quo(quo_u)
  );

  pic_p2g_div u_div_v (
    .clk(clk), .rst_n(rst_n), .go(go),
    .dividend($signed(rd_v_r[VSUM_W-1:0])), .divisor(rd_v_r[WORD_W-1:VSUM_W]),
    .done(done_v), .quo(quo_v)
  );

  assign emp_u = (rd_u_r[WORD_W-1:VSUM_W] == '0);
  assign emp_v = (rd_v_r[WORD_W-1:VSUM_W] == '0);

  always_comb begin
    status.clr_last = (32'(clr_addr_r) == CELLS - 1);
    status.div_done = done_u && done_v;
  end

  // result register
  out_item_t out_r, out_nxt;
  logic      out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= (cmd.out != OUT_NONE);
  end

  always_comb begin
    out_nxt = '0;
    case (cmd.out)
      OUT_PART: begin
        out_nxt.new_pos_x = pxc_r;
        out_nxt.new_pos_y = pyc_r;
        out_nxt.new_vel_x = vxc_r;
        out_nxt.new_vel_y = vyc_r;
      end
      OUT_QRY: begin
        if (oor_r) begin
          out_nxt.u_empty = 1'b1;
          out_nxt.v_empty = 1'b1;
        end else begin
          out_nxt.grid_u  = emp_u ? '0 : quo_u;
          out_nxt.grid_v  = emp_v ? '0 : quo_v;
          out_nxt.u_empty = emp_u;
          out_nxt.v_empty = emp_v;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out != OUT_NONE) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the particle-in-cell particle-to-grid step unit.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import pic_p2g_pkg::*;

  localparam int  MAX_CYCLES = 20_000_000;  // far above the slowest correct run
  localparam int  TAIL_WAIT  = 120;        // tail wait, longer than a query's busy time
  localparam int  IN_W       = $bits(in_item_t);
  localparam longint VSUM_MAX = (64'sd1 <<< 47) - 1;
  localparam longint VSUM_MIN = -(64'sd1 <<< 47);

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  pic_particle_to_grid_step_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Local copy of the registers and the four grid sum stores
  logic [15:0] dt_q, grav_q;
  logic [31:0] u_wsum [CELLS];
  longint      u_vsum [CELLS];
  logic [31:0] v_wsum [CELLS];
  longint      v_vsum [CELLS];

  out_item_t   pending_results[$];
  int          mismatches;
  int          n_transfers, n_particles, n_queries, n_clears, n_nonempty;
  int          cycle_cnt;
  bit          idling_on;
  logic [15:0] last_px, last_py;

  function automatic longint clip16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic void wipe_grids();
    for (int i = 0; i < CELLS; i++) begin
      u_wsum[i] = '0; u_vsum[i] = 0; v_wsum[i] = '0; v_vsum[i] = 0;
    end
  endfunction

  // Saturating accumulate of one bilinear corner
  function automatic void deposit(bit to_u, longint cx, longint cy, longint w, longint vel);
    int     idx;
    longint s;
    if (cx < 0 || cx >= GRID_W || cy < 0 || cy >= GRID_H) return;
    idx = int'(cy * GRID_W + cx);
    if (to_u) begin
      s = longint'(u_wsum[idx]) + w;
      u_wsum[idx] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
      s = u_vsum[idx] + w * vel;
      u_vsum[idx] = (s > VSUM_MAX) ? VSUM_MAX : (s < VSUM_MIN) ? VSUM_MIN : s;
    end else begin
      s = longint'(v_wsum[idx]) + w;
      v_wsum[idx] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
      s = v_vsum[idx] + w * vel;
      v_vsum[idx] = (s > VSUM_MAX) ? VSUM_MAX : (s < VSUM_MIN) ? VSUM_MIN : s;
    end
  endfunction

  function automatic void scatter(bit to_u, longint px, longint py,
                                  longint offx, longint offy, longint vel);
    longint qx, qy, gx, gy, fx, fy;
    qx = px - offx; qy = py - offy;
    gx = qx >>> POS_FRAC_BITS; gy = qy >>> POS_FRAC_BITS;  // floor
    fx = qx - gx * ONE_CELL;   fy = qy - gy * ONE_CELL;
    deposit(to_u, gx,     gy,     (ONE_CELL - fx) * (ONE_CELL - fy), vel);
    deposit(to_u, gx + 1, gy,     fx * (ONE_CELL - fy), vel);
    deposit(to_u, gx,     gy + 1, (ONE_CELL - fx) * fy, vel);
    deposit(to_u, gx + 1, gy + 1, fx * fy, vel);
  endfunction

  function automatic void clamp_axis(ref longint p, ref longint v, input longint hi);
    if (p < LO_BOUND) begin p = LO_BOUND; v = 0; end
    if (p > hi) begin p = hi; v = 0; end
  endfunction

  // Expected result of one transfer; updates the local grid copy
  function automatic out_item_t grid_step(in_item_t it);
    out_item_t r;
    longint    dt, px, py, vx, vy, gd;
    int        idx;
    r = '0;
    case (it.opcode)
      OP_CLEAR: wipe_grids();
      OP_PARTICLE: begin
        dt = longint'(dt_q);
        px = longint'(it.pos_x); py = longint'(it.pos_y);
        vx = longint'(it.vel_x); vy = longint'(it.vel_y);
        gd = (longint'(grav_q) * dt + 32768) >>> 16;
        vy = clip16(vy - gd);
        px += (vx * dt + 32768) >>> 16;
        py += (vy * dt + 32768) >>> 16;
        clamp_axis(px, vx, HI_X);
        clamp_axis(py, vy, HI_Y);
        scatter(1'b1, px, py, 0, HALF_CELL, vx);
        scatter(1'b0, px, py, HALF_CELL, 0, vy);
        r.new_pos_x = px[15:0]; r.new_pos_y = py[15:0];
        r.new_vel_x = vx[15:0]; r.new_vel_y = vy[15:0];
        last_px = px[15:0]; last_py = py[15:0];
      end
      OP_QUERY: begin
        idx = int'(it.cell_y) * GRID_W + int'(it.cell_x);
        if (u_wsum[idx] != 0) r.grid_u = 16'(clip16(u_vsum[idx] / longint'(u_wsum[idx])));
        if (v_wsum[idx] != 0) r.grid_v = 16'(clip16(v_vsum[idx] / longint'(v_wsum[idx])));
        r.u_empty = (u_wsum[idx] == 0);
        r.v_empty = (v_wsum[idx] == 0);
        if (!r.u_empty || !r.v_empty) n_nonempty++;
      end
      default: ;  // unused opcode: all-zero result, no state change
    endcase
    return r;
  endfunction

  // --- drive side ---------------------------------------------------------

  // One transfer: present at the falling edge, hold until taken.
  task automatic send_item(in_item_t it);
    @(negedge clk);
    start   = 1'b1;
    in_data = it;
    do @(posedge clk); while (busy);
    pending_results.insert(pending_results.size(), grid_step(it));
    n_transfers++;
    case (it.opcode)
      OP_CLEAR:    n_clears++;
      OP_PARTICLE: n_particles++;
      OP_QUERY:    n_queries++;
      default: ;
    endcase
    // random sender gap
    if (idling_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(1, 19) - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Register write, only ever issued with the unit idle
  task automatic write_reg(logic idx, logic [15:0] val);
    drain();
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_TIME_STEP) dt_q = val; else grav_q = val;
  endtask

  function automatic in_item_t mk_particle(logic [15:0] px, logic [15:0] py,
                                           logic [15:0] vx, logic [15:0] vy);
    in_item_t it;
    it = '0;
    it.opcode = OP_PARTICLE;
    it.pos_x = px; it.pos_y = py; it.vel_x = vx; it.vel_y = vy;
    it.cell_x = 6'($urandom); it.cell_y = 6'($urandom);  // don't-care bits wiggle
    return it;
  endfunction

  function automatic in_item_t mk_query(logic [5:0] cx, logic [5:0] cy);
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));  // junk in unused fields
    it.opcode = OP_QUERY; it.cell_x = cx; it.cell_y = cy;
    return it;
  endfunction

  function automatic in_item_t mk_op(logic [1:0] op);
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    it.opcode = op;
    return it;
  endfunction

  // Velocity mix: mostly modest, sometimes at the rails
  function automatic logic [15:0] pick_vel();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  // Query near the last particle so most reads land on touched cells
  function automatic in_item_t near_query();
    int cx, cy;
    cx = int'(last_px >> POS_FRAC_BITS) + $urandom_range(0, 2) - 1;
    cy = int'(last_py >> POS_FRAC_BITS) + $urandom_range(0, 2) - 1;
    return mk_query(6'(cx), 6'(cy));
  endfunction

  // --- tests --------------------------------------------------------------

  task automatic test_directed();
    send_item(mk_op(2'd3));                        // unused opcode
    send_item(mk_query(6'd0, 6'd0));               // empty grid
    send_item(mk_query(6'd63, 6'd63));
    send_item(mk_particle(16'h0000, 16'h0000, 16'h8000, 16'h8000));  // low clamp
    send_item(mk_particle(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF));  // high clamp
    send_item(mk_particle(16'h2080, 16'h1040, 16'h0100, 16'hFF00));
    send_item(mk_particle(16'h2000, 16'h2000, 16'h0000, 16'h0000));  // on grid point
    send_item(mk_particle(16'h0180, 16'h3E80, 16'h0000, 16'h0000));  // on both bounds
    send_item(mk_query(6'd1, 6'd1));
    send_item(mk_query(6'd62, 6'd62));
    send_item(mk_query(6'd32, 6'd32));
    send_item(mk_query(6'd32, 6'd31));
    send_item(mk_query(6'd31, 6'd32));
    send_item(mk_query(6'd20, 6'd16));
    send_item(mk_query(6'd2, 6'd62));
    send_item(mk_op(OP_CLEAR));
    send_item(mk_query(6'd32, 6'd32));             // cleared again
    send_item(mk_op(2'd3));
  endtask

  task automatic test_register_settings();
    logic [15:0] dts  [4] = '{16'd0, 16'hFFFF, 16'd4096, 16'd1092};
    logic [15:0] gravs[4] = '{16'hFFFF, 16'd0, 16'd512, 16'd256};
    for (int s = 0; s < 4; s++) begin
      write_reg(CFG_TIME_STEP, dts[s]);
      write_reg(CFG_GRAVITY, gravs[s]);
      for (int k = 0; k < 8; k++) begin
        send_item(mk_particle(16'($urandom_range(256, 16128)),
                              16'($urandom_range(256, 16128)), pick_vel(), pick_vel()));
        send_item(near_query());
      end
    end
  endtask

  task automatic test_random_traffic(int n_items);
    int r;
    for (int i = 0; i < n_items; i++) begin
      if (i > (n_items * 4) / 5) idling_on = 1'b0;  // last stretch back to back
      r = $urandom_range(0, 99);
      if (r < 50)
        send_item(mk_particle(16'($urandom_range(0, 16639)), 16'($urandom_range(0, 16639)),
                              pick_vel(), pick_vel()));
      else if (r < 58)
        send_item(mk_particle(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)));
      else if (r < 85)
        send_item(near_query());
      else if (r < 96)
        send_item(mk_query(6'($urandom), 6'($urandom)));
      else if (r < 98)
        send_item(mk_op(2'd3));
      else
        send_item(mk_op(OP_CLEAR));
    end
  endtask

  // --- result checking ----------------------------------------------------

  task automatic check_field(string fname, logic [15:0] exp_v, logic [15:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected %h, got %h (transfer result %0d)",
                 fname, exp_v, got_v, n_transfers);
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH: unexpected result %h", out_data);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("new_pos_x", exp_r.new_pos_x, out_data.new_pos_x);
        check_field("new_pos_y", exp_r.new_pos_y, out_data.new_pos_y);
        check_field("new_vel_x", exp_r.new_vel_x, out_data.new_vel_x);
        check_field("new_vel_y", exp_r.new_vel_y, out_data.new_vel_y);
        check_field("grid_u", exp_r.grid_u, out_data.grid_u);
        check_field("grid_v", exp_r.grid_v, out_data.grid_v);
        check_field("u_empty", 16'(exp_r.u_empty), 16'(out_data.u_empty));
        check_field("v_empty", 16'(exp_r.v_empty), 16'(out_data.v_empty));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0; start = 1'b0; in_data = '0;
    cfg_we = 1'b0; cfg_index = CFG_TIME_STEP; cfg_data = '0;
    dt_q = TIME_STEP_RST; grav_q = GRAVITY_RST;
    mismatches = 0; n_transfers = 0; n_particles = 0; n_queries = 0;
    n_clears = 0; n_nonempty = 0; cycle_cnt = 0;
    last_px = 16'h2000; last_py = 16'h2000;
    idling_on = 1'b1;
    wipe_grids();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_register_settings();
    test_random_traffic(760);

    drain();
    if (pending_results.size() != 0) mismatches++;
    $display("%0d transfers: %0d particle steps, %0d queries (%0d on touched cells), %0d clears",
             n_transfers, n_particles, n_queries, n_nonempty, n_clears);
    $display("register sweeps incl. zero and full-scale dt and gravity; %0d mismatches",
             mismatches);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
